// File: rtl/plte_pkg.sv
// ----------------------------------------------------------------------------
// plte_pkg
// Shared types, constants and the CRC-32 byte update for the PLTE builder.
// ----------------------------------------------------------------------------
package plte_pkg;

   localparam int          PLTE_MAX_ENTRIES = 256;
   localparam int          PLTE_COUNT_W     = 9;
   localparam int          PLTE_LEN_W       = 11;
   localparam logic [31:0] PLTE_CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] PLTE_CRC_ONES    = 32'hFFFF_FFFF;

   // Entry held between the capture stage and the byte sequencer.
   typedef struct packed {
      logic                  valid;
      logic                  first;   // opens a chunk: length and type bytes
      logic                  last;    // closes a chunk: CRC bytes
      logic [PLTE_LEN_W-1:0] len;     // chunk data length in bytes
      logic [7:0]            ch0;
      logic [7:0]            ch1;
      logic [7:0]            ch2;
   } plte_entry_type;

   // Reflected CRC-32, one byte.
   function automatic logic [31:0] plte_crc_byte(input logic [31:0] c_in,
                                                 input logic [7:0]  b);
      logic [31:0] c;
      c = c_in ^ {24'h00_0000, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = PLTE_CRC_POLY ^ (c >> 1);
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/png_plte_chunk_builder_unit.sv
// ----------------------------------------------------------------------------
// png_plte_chunk_builder_unit
// Builds PNG PLTE chunk bytes, with CRC-32, from palette entries.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one palette entry (three color bytes) per transaction.
//  - rsp_ channel: one chunk byte per transaction in file order. run_last
//    marks the last byte caused by an entry, chunk_end the final CRC byte.
//  - csr_: write palette_count (entries per chunk) while the block is idle;
//    zero acts as one, values above MAX_ENTRIES saturate.
// Entry path: an entry is held in the entry register, and its first byte is
// valid once it has been moved on into the result register.
// Throughput: one byte per cycle while rsp_ready is high, set by the byte-wide result register.
// An entry gives 3 bytes in mid-chunk, 11 when it opens a chunk, 7 when it
// closes one, 15 when it does both. A new entry is taken on the cycle the
// previous entry's last byte goes into the result register.
// Reset: clears the chunk position and CRC, palette_count returns to 256.
// Stall: while rsp_ready is low the result register holds; the entry
// register fills and then req_ready drops.
// ----------------------------------------------------------------------------
module png_plte_chunk_builder_unit
   import plte_pkg::*;
#(
   parameter int MAX_ENTRIES = PLTE_MAX_ENTRIES
) (
   input  logic                    clock,
   input  logic                    reset,
   // entry input
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_channel_first,
   input  logic [7:0]              req_channel_second,
   input  logic [7:0]              req_channel_third,
   // chunk byte output
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_run_last,
   output logic                    rsp_chunk_end,
   // configuration
   input  logic                    csr_write_enable,
   input  logic [PLTE_COUNT_W-1:0] csr_write_data
);

   plte_entry_type entry;
   logic           entry_take;

   // entry register, position in chunk, count register
   plte_entry_stage #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_entry (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_channel_first  (req_channel_first),
      .req_channel_second (req_channel_second),
      .req_channel_third  (req_channel_third),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .entry              (entry),
      .entry_take         (entry_take)
   );

   // byte walk, CRC and result register
   plte_byte_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .entry         (entry),
      .entry_take    (entry_take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_chunk_end (rsp_chunk_end)
   );

endmodule

// File: rtl/plte_entry_stage.sv
// ----------------------------------------------------------------------------
// plte_entry_stage
// Input register for one palette entry, chunk position tracking and the
// palette_count register.
// ----------------------------------------------------------------------------
module plte_entry_stage
   import plte_pkg::*;
#(
   parameter int MAX_ENTRIES = PLTE_MAX_ENTRIES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_channel_first,
   input  logic [7:0]              req_channel_second,
   input  logic [7:0]              req_channel_third,
   input  logic                    csr_write_enable,
   input  logic [PLTE_COUNT_W-1:0] csr_write_data,
   output plte_entry_type          entry,
   input  logic                    entry_take
);

   localparam logic [PLTE_COUNT_W-1:0] MAX_CNT = PLTE_COUNT_W'(MAX_ENTRIES);
   localparam logic [PLTE_COUNT_W-1:0] ONE_CNT = PLTE_COUNT_W'(1);

   logic [PLTE_COUNT_W-1:0] count_ff, count_in;
   logic [PLTE_COUNT_W-1:0] seen_ff, seen_in;
   plte_entry_type          entry_ff, entry_in;
   logic [PLTE_COUNT_W-1:0] eff;
   logic [PLTE_COUNT_W:0]   seen_inc;
   logic                    accept;
   logic                    is_last;

   // zero means one, above the maximum saturates
   always_comb begin
      priority if (count_ff == '0) begin
         eff = ONE_CNT;
      end else if (count_ff > MAX_CNT) begin
         eff = MAX_CNT;
      end else begin
         eff = count_ff;
      end
   end

   assign req_ready = !entry_ff.valid || entry_take;
   assign accept    = req_valid && req_ready;
   assign seen_inc  = {1'b0, seen_ff} + (PLTE_COUNT_W+1)'(1);
   assign is_last   = seen_inc >= {1'b0, eff};

   always_comb begin
      count_in = csr_write_enable ? csr_write_data : count_ff;
      seen_in  = seen_ff;
      entry_in = entry_ff;
      if (entry_take) begin
         entry_in.valid = 1'b0;
      end
      if (accept) begin
         entry_in.valid = 1'b1;
         entry_in.first = (seen_ff == '0);
         entry_in.last  = is_last;
         entry_in.len   = {2'b00, eff} + {1'b0, eff, 1'b0};
         entry_in.ch0   = req_channel_first;
         entry_in.ch1   = req_channel_second;
         entry_in.ch2   = req_channel_third;
         seen_in        = is_last ? '0 : seen_inc[PLTE_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= PLTE_COUNT_W'(256);
         seen_ff        <= '0;
         entry_ff.valid <= 1'b0;
      end else begin
         count_ff       <= count_in;
         seen_ff        <= seen_in;
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.first <= entry_in.first;
      entry_ff.last  <= entry_in.last;
      entry_ff.len   <= entry_in.len;
      entry_ff.ch0   <= entry_in.ch0;
      entry_ff.ch1   <= entry_in.ch1;
      entry_ff.ch2   <= entry_in.ch2;
   end

   assign entry = entry_ff;

endmodule

// File: rtl/plte_byte_seq.sv
// ----------------------------------------------------------------------------
// plte_byte_seq
// Walks the held entry's bytes one per cycle, while the output is not stalled,
// into the result register and keeps the running CRC.
// ----------------------------------------------------------------------------
module plte_byte_seq
   import plte_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  plte_entry_type entry,
   output logic           entry_take,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_run_last,
   output logic           rsp_chunk_end
);

   // byte positions within one entry's run
   localparam logic [3:0] IDX_LEN0 = 4'd0;
   localparam logic [3:0] IDX_LEN1 = 4'd1;
   localparam logic [3:0] IDX_LEN2 = 4'd2;
   localparam logic [3:0] IDX_LEN3 = 4'd3;
   localparam logic [3:0] IDX_P    = 4'd4;
   localparam logic [3:0] IDX_L    = 4'd5;
   localparam logic [3:0] IDX_T    = 4'd6;
   localparam logic [3:0] IDX_E    = 4'd7;
   localparam logic [3:0] IDX_CH0  = 4'd8;
   localparam logic [3:0] IDX_CH1  = 4'd9;
   localparam logic [3:0] IDX_CH2  = 4'd10;
   localparam logic [3:0] IDX_CRC0 = 4'd11;
   localparam logic [3:0] IDX_CRC1 = 4'd12;
   localparam logic [3:0] IDX_CRC2 = 4'd13;
   localparam logic [3:0] IDX_CRC3 = 4'd14;

   logic [3:0]  idx_ff, idx_in;
   logic        mid_ff, mid_in;
   logic [31:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        run_last_ff, run_last_in;
   logic        end_ff, end_in;

   logic [3:0]  cur_idx;
   logic [31:0] crc_out;
   logic        advance, emit, done;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign emit    = entry.valid && advance;
   assign cur_idx = mid_ff ? idx_ff : (entry.first ? IDX_LEN0 : IDX_CH0);
   assign crc_out = crc_ff ^ PLTE_CRC_ONES;
   assign done    = (cur_idx == IDX_CH2 && !entry.last) || cur_idx == IDX_CRC3;
   assign entry_take = emit && done;

   always_comb begin
      unique case (cur_idx)
         IDX_LEN0: byte_in = 8'h00;
         IDX_LEN1: byte_in = 8'h00;
         IDX_LEN2: byte_in = {5'b00000, entry.len[PLTE_LEN_W-1:8]};
         IDX_LEN3: byte_in = entry.len[7:0];
         IDX_P:    byte_in = 8'h50;
         IDX_L:    byte_in = 8'h4C;
         IDX_T:    byte_in = 8'h54;
         IDX_E:    byte_in = 8'h45;
         IDX_CH0:  byte_in = entry.ch0;
         IDX_CH1:  byte_in = entry.ch1;
         IDX_CH2:  byte_in = entry.ch2;
         IDX_CRC0: byte_in = crc_out[31:24];
         IDX_CRC1: byte_in = crc_out[23:16];
         IDX_CRC2: byte_in = crc_out[15:8];
         IDX_CRC3: byte_in = crc_out[7:0];
         default:  byte_in = 8'h00;
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      mid_in       = mid_ff;
      crc_in       = crc_ff;
      rsp_valid_in = advance ? entry.valid : rsp_valid_ff;
      run_last_in  = done;
      end_in       = (cur_idx == IDX_CRC3);
      if (emit) begin
         mid_in = !done;
         idx_in = cur_idx + 4'd1;
         // CRC covers type and data bytes; it restarts with each chunk
         if (cur_idx == IDX_LEN0) begin
            crc_in = PLTE_CRC_ONES;
         end else if (cur_idx >= IDX_P && cur_idx <= IDX_CH2) begin
            crc_in = plte_crc_byte(crc_ff, byte_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff       <= 1'b0;
         crc_ff       <= PLTE_CRC_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         mid_ff       <= mid_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      if (emit) begin
         byte_ff     <= byte_in;
         run_last_ff <= run_last_in;
         end_ff      <= end_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_chunk_end = end_ff;

endmodule

// File: dv/plte_chunk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plte_chunk_checker
// Watches the entry, byte and csr ports of the PLTE chunk builder, predicts
// every chunk byte with its own CRC-32 and compares the byte stream in order.
// ----------------------------------------------------------------------------
module plte_chunk_checker
   import plte_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [7:0]              req_channel_first,
   input  logic [7:0]              req_channel_second,
   input  logic [7:0]              req_channel_third,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [7:0]              rsp_out_byte,
   input  logic                    rsp_run_last,
   input  logic                    rsp_chunk_end,
   input  logic                    csr_write_enable,
   input  logic [PLTE_COUNT_W-1:0] csr_write_data,
   output int                      fail_count,
   output int                      pending_bytes,
   output int                      entries_taken,
   output int                      bytes_checked,
   output int                      chunks_closed
);

   localparam logic [31:0] TYPE_TAG   = 32'h504C_5445;  // "PLTE"

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       chunk_end;
   } chunk_byte_type;

   chunk_byte_type          expected_bytes[$];
   logic [PLTE_COUNT_W-1:0] palette_count_q;
   logic [PLTE_COUNT_W-1:0] entries_in_chunk;
   logic [31:0]             crc_acc;

   function automatic logic [31:0] crc32_shift(input logic [31:0] acc,
                                               input logic [7:0]  data);
      logic [31:0] r;
      r = acc ^ {24'd0, data};
      repeat (8) r = (r >> 1) ^ (PLTE_CRC_POLY & {32{r[0]}});
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic queue_byte(input logic [7:0] data, input logic run_last,
                             input logic chunk_end);
      expected_bytes.push_back(chunk_byte_type'{data: data, run_last: run_last,
                                                chunk_end: chunk_end});
   endtask

   task automatic queue_crc_byte(input logic [7:0] data);
      crc_acc = crc32_shift(crc_acc, data);
      queue_byte(data, 1'b0, 1'b0);
   endtask

   task automatic predict_entry(input logic [7:0] c0, input logic [7:0] c1,
                                input logic [7:0] c2);
      logic [PLTE_COUNT_W-1:0] eff;
      logic                    closes;
      logic [31:0]             len;
      logic [31:0]             crc_out;
      int                      i;
      if (palette_count_q == '0) begin
         eff = PLTE_COUNT_W'(1);
      end else if (palette_count_q > PLTE_MAX_ENTRIES) begin
         eff = PLTE_COUNT_W'(PLTE_MAX_ENTRIES);
      end else begin
         eff = palette_count_q;
      end
      closes = ({1'b0, entries_in_chunk} + 10'd1) >= {1'b0, eff};
      if (entries_in_chunk == '0) begin
         // length is not covered by the CRC, type bytes are
         len     = 32'(eff) * 32'd3;
         crc_acc = PLTE_CRC_ONES;
         for (i = 3; i >= 0; i--) queue_byte(len[8*i +: 8], 1'b0, 1'b0);
         for (i = 3; i >= 0; i--) queue_crc_byte(TYPE_TAG[8*i +: 8]);
      end
      queue_crc_byte(c0);
      queue_crc_byte(c1);
      crc_acc = crc32_shift(crc_acc, c2);
      queue_byte(c2, !closes, 1'b0);
      if (closes) begin
         crc_out = crc_acc ^ PLTE_CRC_ONES;
         for (i = 3; i >= 1; i--) queue_byte(crc_out[8*i +: 8], 1'b0, 1'b0);
         queue_byte(crc_out[7:0], 1'b1, 1'b1);
         crc_acc          = PLTE_CRC_ONES;
         entries_in_chunk = '0;
      end else begin
         entries_in_chunk = entries_in_chunk + PLTE_COUNT_W'(1);
      end
   endtask

   always @(posedge clock) begin
      chunk_byte_type want;
      if (reset) begin
         palette_count_q  = PLTE_COUNT_W'(PLTE_MAX_ENTRIES);
         crc_acc          = PLTE_CRC_ONES;
         entries_in_chunk = '0;
         fail_count       = 0;
         entries_taken    = 0;
         bytes_checked    = 0;
         chunks_closed    = 0;
         expected_bytes.delete();
      end else begin
         if (csr_write_enable) begin
            palette_count_q = csr_write_data;
         end
         // compare before predicting so a stray byte never matches new work
         if (rsp_valid && rsp_ready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h", rsp_out_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data) begin
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_out_byte, want.data));
               end
               if (rsp_run_last !== want.run_last) begin
                  report_mismatch($sformatf("run_last %b, expected %b (byte %02h)",
                                            rsp_run_last, want.run_last, want.data));
               end
               if (rsp_chunk_end !== want.chunk_end) begin
                  report_mismatch($sformatf("chunk_end %b, expected %b (byte %02h)",
                                            rsp_chunk_end, want.chunk_end, want.data));
               end
               if (want.chunk_end) begin
                  chunks_closed++;
               end
            end
         end
         if (req_valid && req_ready) begin
            entries_taken++;
            predict_entry(req_channel_first, req_channel_second, req_channel_third);
         end
      end
      pending_bytes = expected_bytes.size();
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives palette entries and palette_count writes into the PLTE chunk
// builder under random idling and backpressure; a checker beside the block
// predicts and compares every chunk byte.
// ----------------------------------------------------------------------------
module tb;
   import plte_pkg::*;

   localparam int ENTRY_TARGET  = 420;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 3;     // idle margin before a csr write
   localparam int TAIL_CYCLES   = 20;

   logic                    clock              = 1'b0;
   logic                    reset              = 1'b1;
   logic                    req_valid          = 1'b0;
   logic                    req_ready;
   logic [7:0]              req_channel_first  = 8'h00;
   logic [7:0]              req_channel_second = 8'h00;
   logic [7:0]              req_channel_third  = 8'h00;
   logic                    rsp_valid;
   logic                    rsp_ready          = 1'b0;
   logic [7:0]              rsp_out_byte;
   logic                    rsp_run_last;
   logic                    rsp_chunk_end;
   logic                    csr_write_enable   = 1'b0;
   logic [PLTE_COUNT_W-1:0] csr_write_data     = '0;

   // stimulus-owned knobs read by the ready process
   logic req_steady   = 1'b0;
   logic rsp_steady   = 1'b0;
   logic hold_tog     = 1'b0;
   logic hold_tog_ack = 1'b0;
   int   hold_left    = 0;

   int fail_count;
   int pending_bytes;
   int entries_taken;
   int bytes_checked;
   int chunks_closed;
   int entries_sent = 0;
   int count_writes = 0;
   int cycle_count  = 0;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   png_plte_chunk_builder_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_channel_first  (req_channel_first),
      .req_channel_second (req_channel_second),
      .req_channel_third  (req_channel_third),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_chunk_end      (rsp_chunk_end),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   plte_chunk_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_channel_first  (req_channel_first),
      .req_channel_second (req_channel_second),
      .req_channel_third  (req_channel_third),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_chunk_end      (rsp_chunk_end),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .fail_count         (fail_count),
      .pending_bytes      (pending_bytes),
      .entries_taken      (entries_taken),
      .bytes_checked      (bytes_checked),
      .chunks_closed      (chunks_closed)
   );

   // Byte receiver. A toggle of hold_tog starts a long hold-off that this
   // process counts down itself; otherwise ready is random (~37% idle) or
   // steady high during the no-idle stretch.
   always @(posedge clock) begin
      if (hold_tog != hold_tog_ack) begin
         hold_tog_ack <= hold_tog;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 37);
      end
   end

   // Watchdog: the slowest legal run is far below this.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_count, pending_bytes);
      $display("FAILED: results differ");
      $finish;
   end

   // Colour byte biased toward the extremes.
   function automatic logic [7:0] color_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Mostly small counts so chunks close often; zero, max and oversize too.
   function automatic logic [PLTE_COUNT_W-1:0] pick_count();
      case ($urandom_range(9))
         0:       return '0;
         1:       return PLTE_COUNT_W'(1);
         2:       return PLTE_COUNT_W'(PLTE_MAX_ENTRIES);
         3:       return PLTE_COUNT_W'($urandom_range(511, PLTE_MAX_ENTRIES + 1));
         4, 5:    return PLTE_COUNT_W'($urandom_range(4, 2));
         default: return PLTE_COUNT_W'($urandom_range(16, 1));
      endcase
   endfunction

   // One entry transaction; random idle cycles ahead of it unless steady.
   task automatic send_entry(input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2);
      while (!req_steady && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_channel_first  <= c0;
      req_channel_second <= c1;
      req_channel_third  <= c2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      entries_sent++;
   endtask

   // Sender pause: wait until every predicted byte has been taken.
   task automatic drain_bytes();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_bytes != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // palette_count is only written with the block idle.
   task automatic write_count(input logic [PLTE_COUNT_W-1:0] value);
      drain_bytes();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      count_writes++;
   endtask

   initial begin
      int phase;
      int n;
      int i;
      phase = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // reset count (256): opening entry reports length 0x300
      send_entry(8'h00, 8'h00, 8'h00);
      // shrink mid-chunk to 1: next entry closes the open chunk
      write_count(9'd1);
      send_entry(8'hFF, 8'hFF, 8'hFF);
      // one-entry chunks: open and close on the same entry
      send_entry(8'h00, 8'hFF, 8'h00);
      send_entry(8'hAA, 8'h55, 8'hAA);
      // zero count behaves as one
      write_count(9'd0);
      send_entry(8'h55, 8'hAA, 8'h55);
      // three-entry chunk: first, middle, last
      write_count(9'd3);
      send_entry(8'h01, 8'h80, 8'h7F);
      send_entry(8'hFE, 8'h7F, 8'h80);
      send_entry(8'h12, 8'h34, 8'h56);
      // oversize count saturates to the maximum
      write_count(9'd511);
      send_entry(8'hFF, 8'h00, 8'hFF);
      send_entry(8'hC3, 8'h3C, 8'h99);
      write_count(9'd256);
      send_entry(8'h0F, 8'hF0, 8'h66);
      // shrink below entries already taken: closes at once
      write_count(9'd2);
      send_entry(8'h80, 8'h01, 8'hFE);
      write_count(9'd300);
      send_entry(8'h11, 8'h22, 8'h33);
      write_count(9'd4);
      send_entry(8'h44, 8'h55, 8'h66);
      send_entry(8'h77, 8'h88, 8'h99);
      send_entry(8'hAB, 8'hCD, 8'hEF);

      // --- random phases ---
      while (entries_sent < ENTRY_TARGET) begin
         write_count(pick_count());
         n = $urandom_range(24, 1);
         if (phase == 3) begin
            // long stretch with no idling on either side
            req_steady <= 1'b1;
            rsp_steady <= 1'b1;
            n = 60;
         end else if (phase == 6) begin
            // receiver holds off while entries keep coming: input stalls
            hold_tog   <= ~hold_tog;
            req_steady <= 1'b1;
            n = 20;
         end
         for (i = 0; i < n; i++) begin
            send_entry(color_byte(), color_byte(), color_byte());
            if (phase != 3 && phase != 6 && $urandom_range(29) == 0) begin
               drain_bytes();
            end
         end
         req_steady <= 1'b0;
         rsp_steady <= 1'b0;
         phase++;
      end

      drain_bytes();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d entries, %0d chunk bytes, %0d closed chunks",
               entries_taken, bytes_checked, chunks_closed);
      $display("across %0d palette_count settings incl. zero, max and oversize",
               count_writes);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
